// ===== sv/ddt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddt_pkg
// Types and codes shared by the discovered device table.
// ----------------------------------------------------------------------------
package ddt_pkg;

  localparam int ADDR_W  = 48;
  localparam int CLASS_W = 24;
  localparam int RSSI_W  = 8;
  localparam int TIME_W  = 32;
  localparam int RIDX_W  = 5;
  localparam int OIDX_W  = 5;
  localparam int OCNT_W  = 6;
  localparam int STAT_W  = 3;
  localparam int CMD_W   = 2;
  // Index and count values are padded to this width before being trimmed.
  localparam int PAD_W   = 9;

  localparam logic [CMD_W-1:0] CMD_INGEST = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_UPDATED = 3'd0;
  localparam logic [STAT_W-1:0] ST_ADDED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd2;
  localparam logic [STAT_W-1:0] ST_CLEARED = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_OK = 3'd4;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd5;

  typedef struct packed {
    logic [ADDR_W-1:0]        address;
    logic [CLASS_W-1:0]       dev_class;
    logic signed [RSSI_W-1:0] strength;
    logic [TIME_W-1:0]        seen_ms;
  } entry_t;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [ADDR_W-1:0]        device_address;
    logic [CLASS_W-1:0]       class_code;
    logic signed [RSSI_W-1:0] signal_strength;
    logic                     strength_present;
    logic [TIME_W-1:0]        timestamp_ms;
    logic [RIDX_W-1:0]        read_index;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OIDX_W-1:0] entry_index;
    logic [OCNT_W-1:0] entry_count;
    entry_t            entry;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/ddt_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddt_mem
// Entry storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ddt_mem
  import ddt_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire entry_t           wr_data,
  input  wire logic             rd_en,
  input  wire logic [IDX_W-1:0] rd_addr,
  output entry_t                rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/ddt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ddt_ctrl
// Sequencer: walks the filled entries through one address comparator,
// updates or appends, and holds the result in an output register.
// ----------------------------------------------------------------------------
module ddt_ctrl
  import ddt_pkg::*;
#(
  parameter int DEPTH = 32,
  parameter int IDX_W = 5,
  parameter int CNT_W = 6
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire req_t             in_req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output result_t               out_res,
  output logic                  wr_en,
  output logic [IDX_W-1:0]      wr_addr,
  output entry_t                wr_data,
  output logic                  rd_en,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire entry_t           rd_data
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_APPEND = 2'd2;
  localparam logic [1:0] S_RESULT = 2'd3;
  // Read waits for the memory; tracked by a flag in the result state.

  logic [1:0]       state, state_next;
  req_t             req;
  logic [IDX_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] count, count_next;
  result_t          res, res_next;
  logic             rd_pending, rd_pending_next;
  logic             out_load;

  entry_t           upd_entry;
  entry_t           add_entry;
  logic [PAD_W-1:0] ridx_pad;
  logic [PAD_W-1:0] idx_pad;
  logic [CNT_W-1:0] idx_inc;

  function automatic result_t make_res(input logic [STAT_W-1:0] st,
                                       input logic [PAD_W-1:0]  ix,
                                       input logic [CNT_W-1:0]  cnt,
                                       input entry_t            e);
    result_t          r;
    logic [PAD_W-1:0] cnt_pad;
    cnt_pad       = PAD_W'(cnt);
    r.status      = st;
    r.entry_index = ix[OIDX_W-1:0];
    r.entry_count = cnt_pad[OCNT_W-1:0];
    r.entry       = e;
    return r;
  endfunction

  assign ridx_pad = PAD_W'(in_req.read_index);
  assign idx_pad  = PAD_W'(idx);
  assign idx_inc  = CNT_W'(idx) + CNT_W'(1);

  always_comb begin
    upd_entry           = rd_data;
    upd_entry.dev_class = req.class_code;
    upd_entry.seen_ms   = req.timestamp_ms;
    if (req.strength_present) begin
      upd_entry.strength = req.signal_strength;
    end
    add_entry.address   = req.device_address;
    add_entry.dev_class = req.class_code;
    add_entry.strength  = req.strength_present ? req.signal_strength : '0;
    add_entry.seen_ms   = req.timestamp_ms;
  end

  always_comb begin
    state_next      = state;
    idx_next        = idx;
    count_next      = count;
    res_next        = res;
    rd_pending_next = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = upd_entry;
    rd_en           = 1'b0;
    rd_addr         = idx;
    in_ready        = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req.command)
            CMD_INGEST: begin
              if (count == '0) begin
                state_next = S_APPEND;
              end else begin
                idx_next   = '0;
                rd_en      = 1'b1;
                rd_addr    = '0;
                state_next = S_SCAN;
              end
            end
            CMD_CLEAR: begin
              count_next = '0;
              res_next   = make_res(ST_CLEARED, '0, '0, '0);
              state_next = S_RESULT;
            end
            CMD_READ: begin
              if (ridx_pad < PAD_W'(count)) begin
                idx_next        = ridx_pad[IDX_W-1:0];
                rd_en           = 1'b1;
                rd_addr         = ridx_pad[IDX_W-1:0];
                rd_pending_next = 1'b1;
                state_next      = S_RESULT;
              end else begin
                res_next   = make_res(ST_RANGE, ridx_pad, count, '0);
                state_next = S_RESULT;
              end
            end
            default: begin
              // unused command: drop without a result
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_data.address == req.device_address) begin
          wr_en      = 1'b1;
          wr_addr    = idx;
          wr_data    = upd_entry;
          res_next   = make_res(ST_UPDATED, idx_pad, count, upd_entry);
          state_next = S_RESULT;
        end else if (idx_inc < count) begin
          idx_next = idx_inc[IDX_W-1:0];
          rd_en    = 1'b1;
          rd_addr  = idx_inc[IDX_W-1:0];
        end else begin
          state_next = S_APPEND;
        end
      end
      S_APPEND: begin
        if (count < CNT_W'(DEPTH)) begin
          wr_en      = 1'b1;
          wr_addr    = count[IDX_W-1:0];
          wr_data    = add_entry;
          count_next = count + CNT_W'(1);
          res_next   = make_res(ST_ADDED, PAD_W'(count), count + CNT_W'(1), add_entry);
        end else begin
          res_next = make_res(ST_FULL, '0, count, '0);
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (rd_pending) begin
          // read data arrives this cycle
          res_next   = make_res(ST_READ_OK, idx_pad, count, rd_data);
        end else if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign out_load = (state == S_RESULT) && !rd_pending && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      count      <= count_next;
      rd_pending <= rd_pending_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    res <= res_next;
    if (in_valid && in_ready) begin
      req <= in_req;
    end
    if (out_load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/discovered_device_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// discovered_device_table
// Lookup-or-append table of radio devices keyed by a 48-bit address.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_ group, the command in s_tuser. An ingest
// searches the filled entries from index 0 up, refreshing a matching entry
// or appending a new one; a clear empties the table; a read returns one
// entry. Every request except the unused command gives one result on the
// m_ group, its status in m_tuser.
// Timing: a single 48-bit comparator and the one read port of the entry
// memory are shared; one filled entry is compared per cycle. An ingest that
// matches goes through the scan and result states; a new or dropped record
// also goes through the append state, with no scan on an empty table. A
// clear or an out-of-range read goes straight to the result state, a good
// read waits there for the memory data. s_tready is high only while the
// sequencer is idle, so one request is in work at a time.
// Reset empties the table and drops any result held. A stalled receiver
// holds the result in the output register; the next request is still
// taken and waits in the result stage until the register frees.
// ----------------------------------------------------------------------------
module discovered_device_table
  import ddt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // device_address, class_code, signal_strength, timestamp_ms, read_index
  input  wire logic [119:0] s_tdata,
  // command, strength_present
  input  wire logic [2:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // entry_index, entry_count, entry_address, entry_class, entry_strength,
  // entry_seen_ms
  output logic [127:0]      m_tdata,
  // status
  output logic [2:0]        m_tuser
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  req_t             in_req;
  result_t          out_res;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  entry_t           rd_data;

  assign in_req.command          = s_tuser[1:0];
  assign in_req.strength_present = s_tuser[2];
  assign in_req.device_address   = s_tdata[47:0];
  assign in_req.class_code       = s_tdata[71:48];
  assign in_req.signal_strength  = s_tdata[79:72];
  assign in_req.timestamp_ms     = s_tdata[111:80];
  assign in_req.read_index       = s_tdata[116:112];

  assign m_tuser = out_res.status;
  assign m_tdata = {5'd0,
                    out_res.entry.seen_ms,
                    out_res.entry.strength,
                    out_res.entry.dev_class,
                    out_res.entry.address,
                    out_res.entry_count,
                    out_res.entry_index};

  ddt_ctrl #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (in_req),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  ddt_mem #(
    .DEPTH (TABLE_ENTRIES),
    .IDX_W (IDX_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser <= ST_RANGE))
    else $error("result status out of range");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_CLEARED) |-> (m_tdata[10:5] == 6'd0))
    else $error("clear result shows a nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_FULL) |-> (m_tdata[10:5] == 6'(TABLE_ENTRIES)))
    else $error("dropped record while table not full");

  a_added_in_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_ADDED) |-> (m_tdata[10:5] != 6'd0))
    else $error("append result shows an empty table");

endmodule
`default_nettype wire

// ===== bench/ddt_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddt_checker
// Watches both stream channels of the discovered device table, keeps its own
// copy of the table, predicts the outcome of each request that gives one and
// compares every returned result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module ddt_checker
  import ddt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [119:0] s_tdata,
  input  logic [2:0]   s_tuser,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [127:0] m_tdata,
  input  logic [2:0]   m_tuser,
  output int           failures,
  output int           pending,
  output int           results_checked,
  output int           refreshed,
  output int           full_drops,
  output int           range_reads
);

  entry_t  known_devices [TABLE_ENTRIES];
  int      known_count;
  result_t expected_outcomes [$];

  initial begin
    failures        = 0;
    pending         = 0;
    results_checked = 0;
    refreshed       = 0;
    full_drops      = 0;
    range_reads     = 0;
    known_count     = 0;
  end

  // Apply one request to the shadow table; returns 0 when no result follows.
  function automatic bit table_outcome(input req_t rq, output result_t res);
    int hit;
    hit = -1;
    res = '0;
    case (rq.command)
      CMD_INGEST: begin
        for (int i = 0; i < known_count; i++) begin
          if (hit < 0 && known_devices[i].address == rq.device_address) hit = i;
        end
        if (hit >= 0) begin
          known_devices[hit].dev_class = rq.class_code;
          known_devices[hit].seen_ms   = rq.timestamp_ms;
          if (rq.strength_present) known_devices[hit].strength = rq.signal_strength;
          res.status = ST_UPDATED;
        end else if (known_count < TABLE_ENTRIES) begin
          hit = known_count;
          known_devices[hit].address   = rq.device_address;
          known_devices[hit].dev_class = rq.class_code;
          known_devices[hit].strength  = rq.strength_present ? rq.signal_strength : '0;
          known_devices[hit].seen_ms   = rq.timestamp_ms;
          known_count++;
          res.status = ST_ADDED;
        end else begin
          res.status = ST_FULL;
        end
        if (hit >= 0) begin
          res.entry_index = OIDX_W'(hit);
          res.entry       = known_devices[hit];
        end
      end
      CMD_CLEAR: begin
        known_count = 0;
        res.status  = ST_CLEARED;
      end
      CMD_READ: begin
        res.entry_index = rq.read_index;
        if (int'(rq.read_index) < known_count) begin
          res.status = ST_READ_OK;
          res.entry  = known_devices[rq.read_index];
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: return 1'b0;
    endcase
    res.entry_count = OCNT_W'(known_count);
    return 1'b1;
  endfunction

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      failures++;
      $display("t=%0t %s mismatch: expected 0x%0h, actual 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    req_t    rq;
    result_t want;
    result_t got;
    if (rst) begin
      known_count = 0;
      expected_outcomes.delete();
    end else begin
      // Retire the returned result first: it can never belong to a request
      // taken in this same cycle.
      if (m_tvalid && m_tready) begin
        got.status          = m_tuser;
        got.entry_index     = m_tdata[4:0];
        got.entry_count     = m_tdata[10:5];
        got.entry.address   = m_tdata[58:11];
        got.entry.dev_class = m_tdata[82:59];
        got.entry.strength  = m_tdata[90:83];
        got.entry.seen_ms   = m_tdata[122:91];
        if (expected_outcomes.size() == 0) begin
          failures++;
          $display("t=%0t unexpected result: expected none, actual status %0d", $time,
                   got.status);
        end else begin
          want = expected_outcomes.pop_front();
          results_checked++;
          compare_field("status", 64'(want.status), 64'(got.status));
          compare_field("entry_index", 64'(want.entry_index), 64'(got.entry_index));
          compare_field("entry_count", 64'(want.entry_count), 64'(got.entry_count));
          compare_field("entry_address", 64'(want.entry.address),
                        64'(got.entry.address));
          compare_field("entry_class", 64'(want.entry.dev_class),
                        64'(got.entry.dev_class));
          compare_field("entry_strength", 64'($unsigned(want.entry.strength)),
                        64'($unsigned(got.entry.strength)));
          compare_field("entry_seen_ms", 64'(want.entry.seen_ms),
                        64'(got.entry.seen_ms));
          if (want.status == ST_UPDATED) refreshed++;
          if (want.status == ST_FULL) full_drops++;
          if (want.status == ST_RANGE) range_reads++;
        end
      end
      if (s_tvalid && s_tready) begin
        rq.command          = s_tuser[1:0];
        rq.strength_present = s_tuser[2];
        rq.device_address   = s_tdata[47:0];
        rq.class_code       = s_tdata[71:48];
        rq.signal_strength  = s_tdata[79:72];
        rq.timestamp_ms     = s_tdata[111:80];
        rq.read_index       = s_tdata[116:112];
        if (table_outcome(rq, want)) expected_outcomes.push_back(want);
      end
    end
    pending = expected_outcomes.size();
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives ingest, clear and read requests into the discovered device table
// under several idling patterns, one long output stall included, and gives
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
  import ddt_pkg::*;

  localparam int TABLE_ENTRIES  = 32;
  localparam int PHASE_ITEMS    = 300;
  localparam int POOL_SIZE      = 40;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 2 * TABLE_ENTRIES + 10;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic         clk      = 1'b0;
  logic         rst      = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [119:0] s_tdata  = '0;
  logic [2:0]   s_tuser  = '0;
  logic         m_tready = 1'b0;
  logic         s_tready;
  logic         m_tvalid;
  logic [127:0] m_tdata;
  logic [2:0]   m_tuser;

  int failures;
  int pending;
  int results_checked;
  int refreshed;
  int full_drops;
  int range_reads;

  int requests_sent  = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int stalled_cycles = 0;
  int hold_left      = 0;
  bit hold_req       = 1'b0;
  bit hold_ack       = 1'b0;

  logic [ADDR_W-1:0] address_pool [POOL_SIZE];

  always #5 clk = ~clk;

  discovered_device_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  ddt_checker #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) checker_i (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .m_tuser        (m_tuser),
    .failures       (failures),
    .pending        (pending),
    .results_checked(results_checked),
    .refreshed      (refreshed),
    .full_drops     (full_drops),
    .range_reads    (range_reads)
  );

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Give up once nothing has moved on either channel for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  function automatic logic [ADDR_W-1:0] random_address();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic req_t build(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                 input logic [CLASS_W-1:0] cls,
                                 input logic signed [RSSI_W-1:0] rssi, input logic present,
                                 input logic [TIME_W-1:0] ts, input logic [RIDX_W-1:0] idx);
    req_t rq;
    rq.command          = cmd;
    rq.device_address   = addr;
    rq.class_code       = cls;
    rq.signal_strength  = rssi;
    rq.strength_present = present;
    rq.timestamp_ms     = ts;
    rq.read_index       = idx;
    return rq;
  endfunction

  // Random payload; fields the command ignores still toggle.
  function automatic req_t random_req(input logic [CMD_W-1:0] cmd,
                                      input logic [ADDR_W-1:0] addr);
    return build(cmd, addr, CLASS_W'($urandom), RSSI_W'($urandom), 1'($urandom),
                 $urandom, RIDX_W'($urandom));
  endfunction

  function automatic logic [ADDR_W-1:0] known_or_fresh_address();
    if ($urandom_range(99) < 75) return address_pool[$urandom_range(POOL_SIZE - 1)];
    return random_address();
  endfunction

  task automatic send(input req_t rq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, rq.read_index, rq.timestamp_ms, rq.signal_strength,
                 rq.class_code, rq.device_address};
    s_tuser  <= {rq.strength_present, rq.command};
    do @(posedge clk); while (!s_tready);
    if (rq.command != CMD_UNUSED) requests_sent++;
  endtask

  task automatic fill_burst(input int lo, input int hi);
    repeat ($urandom_range(lo, hi)) send(random_req(CMD_INGEST, random_address()));
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct, input int n_items);
    int target;
    int pick;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    target         = requests_sent + n_items;
    // Start from an empty table and run it into the full state.
    send(random_req(CMD_CLEAR, random_address()));
    fill_burst(TABLE_ENTRIES + 2, TABLE_ENTRIES + 6);
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        send(random_req(CMD_CLEAR, random_address()));
      end else if (pick < 6) begin
        send(random_req(CMD_UNUSED, random_address()));
      end else if (pick < 10) begin
        fill_burst(10, 40);
      end else if (pick < 32) begin
        send(random_req(CMD_READ, known_or_fresh_address()));
      end else begin
        send(random_req(CMD_INGEST, known_or_fresh_address()));
      end
    end
  endtask

  initial begin
    address_pool[0] = '0;
    address_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) address_pool[i] = random_address();

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, field extremes, refresh with and without strength.
    send(build(CMD_READ, '0, '0, '0, 1'b0, '0, 5'd0));
    send(build(CMD_READ, '1, '1, '1, 1'b1, '1, 5'd31));
    send(build(CMD_INGEST, '0, '0, -8'sd128, 1'b1, '0, 5'd0));
    send(build(CMD_INGEST, '1, '1, 8'sd127, 1'b1, '1, 5'd31));
    send(build(CMD_INGEST, '0, 24'h123456, 8'sd55, 1'b0, 32'd5, 5'd0));
    send(build(CMD_INGEST, 48'h5555_aaaa_5555, 24'haaaaaa, -8'sd1, 1'b0, 32'h5555_aaaa,
               5'd10));
    send(build(CMD_INGEST, '1, 24'h555555, -8'sd1, 1'b1, 32'haaaa_5555, 5'd21));
    send(build(CMD_INGEST, 48'haaaa_5555_aaaa, 24'h0f0f0f, 8'sd0, 1'b1, 32'd7, 5'd0));
    for (int i = 0; i < 6; i++) begin
      send(build(CMD_READ, '0, '0, '0, 1'b0, '0, RIDX_W'(i)));
    end
    send(build(CMD_READ, '0, '0, '0, 1'b0, '0, 5'd31));
    send(build(CMD_UNUSED, '1, '1, '1, 1'b1, '1, 5'd31));
    send(build(CMD_CLEAR, '0, '0, '0, 1'b0, '0, 5'd0));
    send(build(CMD_READ, '0, '0, '0, 1'b0, '0, 5'd0));
    send(build(CMD_INGEST, '1, 24'hfedcba, 8'sd3, 1'b0, 32'd9, 5'd0));
    send(build(CMD_READ, '0, '0, '0, 1'b0, '0, 5'd0));

    // Stall the output long enough to back the table up into its input.
    hold_req <= ~hold_req;
    repeat (20) send(random_req(CMD_INGEST, known_or_fresh_address()));

    random_phase(0, 0, PHASE_ITEMS);
    random_phase(47, 0, PHASE_ITEMS);
    random_phase(0, 47, PHASE_ITEMS);
    random_phase(21, 21, PHASE_ITEMS);
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d requests across four idling phases; %0d results checked.",
             requests_sent, results_checked);
    $display("Included %0d refreshed entries, %0d drops on a full table, %0d bad reads.",
             refreshed, full_drops, range_reads);
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== discovered_device_table.f =====
sv/ddt_pkg.sv
sv/ddt_mem.sv
sv/ddt_ctrl.sv
sv/discovered_device_table.sv
bench/ddt_checker.sv
bench/testbench.sv
